>>> design/retransmit_inflight_table_top_macros.svh
// assertion macros for the retransmit inflight table checker
// used by retransmit_inflight_table_chk.sv only
`ifndef RETRANSMIT_INFLIGHT_TABLE_TOP_MACROS_SVH
`define RETRANSMIT_INFLIGHT_TABLE_TOP_MACROS_SVH

// same-cycle implication, quiet during reset
`define RIT_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rit check failed");

// next-cycle implication, also checked across reset
`define RIT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("rit check failed");

`endif

>>> design/rit_pkg.sv
// shared types and constants for the retransmit inflight table
// no dependencies
`default_nettype none
package rit_pkg;
   localparam int DEPTH_DEF = 16;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_RETRY_LIMIT = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESEND_INTERVAL = 8'd1;
   localparam logic [7:0] RETRY_LIMIT_RST = 8'd3;
   localparam logic [15:0] RESEND_INTERVAL_RST = 16'd10;
   localparam logic [1:0] CMD_ADD = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_CHECK = 2'd2;
   localparam logic [1:0] CMD_FORCE = 2'd3;

   typedef enum logic [1:0] {
      OP_ADD, OP_REMOVE, OP_CHECK, OP_FORCE
   } op_type;

   typedef enum logic [2:0] {
      K_ADDED = 3'd0, K_FULL = 3'd1, K_REMOVED = 3'd2, K_NOTFOUND = 3'd3,
      K_RESEND = 3'd4, K_FAILED = 3'd5, K_FORCE = 3'd6, K_DONE = 3'd7
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ADD, ST_RM_SCAN, ST_RM_SHIFT, ST_CHK_COUNT, ST_CHK_SCAN,
      ST_FORCE, ST_DONE
   } state_type;

   typedef struct packed {
      op_type      op;
      logic [63:0] id;
      logic [15:0] size;
      logic [31:0] now;
      logic        offline;
   } item_type;

   typedef struct packed {
      logic [7:0]  retry_limit;
      logic [15:0] resend_interval;
   } cfg_type;
endpackage
`default_nettype wire

>>> design/retransmit_inflight_table_top.sv
// top level of the retransmit inflight table: csr registers, front and back
// depends on rit_pkg, rit_front, rit_back
//
// usage:
//   requests enter on req_* when start is high and busy is low; a two-entry
//   queue lets a request be taken while the previous one is still executing.
//   results appear on rsp_* for one cycle each, marked by rsp_valid; the
//   receiver cannot stall, so every result is consumed as it is shown.
//   each command ends with a done result that carries rsp_last.
//   a command is dispatched from the queue in idle; add then gives add/full
//   and done results; remove walks one entry per cycle until it finds the id
//   or runs past the fill, then gives removed or notfound and done; check
//   makes a failure counting pass then the resend pass; force resend walks
//   every entry; a new command starts only after the last done result.
//   csr writes (csr_index 0 retry_limit, 1 resend_interval) are always ready.
//   reset empties the table and the queue and restores retry_limit 3 and
//   resend_interval 10; no clearing pass is needed.
`default_nettype none
module retransmit_inflight_table_top #(
   parameter int TABLE_DEPTH = rit_pkg::DEPTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [1:0]                       req_cmd,
   input  wire logic [63:0]                      req_msg_id,
   input  wire logic [15:0]                      req_msg_size,
   input  wire logic [31:0]                      req_now_time,
   input  wire logic                             req_offline,
   output logic                                  rsp_valid,
   output logic [2:0]                            rsp_kind,
   output logic [63:0]                           rsp_out_id,
   output logic [15:0]                           rsp_out_size,
   output logic [7:0]                            rsp_out_retries,
   output logic                                  rsp_table_empty,
   output logic                                  rsp_last,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [rit_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [rit_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   rit_pkg::cfg_type  cfg_ff, cfg_in;
   rit_pkg::item_type q_item;
   logic q_valid, q_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == rit_pkg::CSR_RETRY_LIMIT) begin
            cfg_in.retry_limit = csr_wdata[7:0];
         end else if (csr_index == rit_pkg::CSR_RESEND_INTERVAL) begin
            cfg_in.resend_interval = csr_wdata[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.retry_limit <= rit_pkg::RETRY_LIMIT_RST;
         cfg_ff.resend_interval <= rit_pkg::RESEND_INTERVAL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rit_front u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_msg_id(req_msg_id), .req_msg_size(req_msg_size),
      .req_now_time(req_now_time), .req_offline(req_offline),
      .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
   );

   rit_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
      .rsp_valid(rsp_valid), .rsp_kind(rsp_kind), .rsp_out_id(rsp_out_id),
      .rsp_out_size(rsp_out_size), .rsp_out_retries(rsp_out_retries),
      .rsp_table_empty(rsp_table_empty), .rsp_last(rsp_last)
   );
endmodule
`default_nettype wire

>>> design/rit_front.sv
// front end: accepts requests, decodes the command, two-entry queue
// depends on rit_pkg
`default_nettype none
module rit_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire logic [1:0]      req_cmd,
   input  wire logic [63:0]     req_msg_id,
   input  wire logic [15:0]     req_msg_size,
   input  wire logic [31:0]     req_now_time,
   input  wire logic            req_offline,
   output logic                 q_valid,
   output rit_pkg::item_type    q_item,
   input  wire logic            q_pop
);
   rit_pkg::item_type slot_ff [2];
   rit_pkg::item_type new_item;
   logic [1:0] cnt_ff, cnt_in;
   logic       rp_ff, rp_in, wp_ff, wp_in;
   logic       push;

   always_comb begin
      unique case (req_cmd)
         rit_pkg::CMD_ADD:    new_item.op = rit_pkg::OP_ADD;
         rit_pkg::CMD_REMOVE: new_item.op = rit_pkg::OP_REMOVE;
         rit_pkg::CMD_CHECK:  new_item.op = rit_pkg::OP_CHECK;
         default:             new_item.op = rit_pkg::OP_FORCE;
      endcase
      new_item.id = req_msg_id;
      new_item.size = req_msg_size;
      new_item.now = req_now_time;
      new_item.offline = req_offline;
   end

   assign busy = (cnt_ff == 2'd2);
   assign push = start && !busy;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item = slot_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop);
      rp_in = rp_ff ^ q_pop;
      wp_in = wp_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rp_ff <= 1'b0;
         wp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rp_ff <= rp_in;
         wp_ff <= wp_in;
      end
      if (push) begin
         slot_ff[wp_ff] <= new_item;
      end
   end
endmodule
`default_nettype wire

>>> design/rit_back.sv
// back end: executes commands against the entry table, one command at a time
// depends on rit_pkg
`default_nettype none
module rit_back #(
   parameter int TABLE_DEPTH = rit_pkg::DEPTH_DEF
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire rit_pkg::cfg_type cfg,
   input  wire logic            q_valid,
   input  wire rit_pkg::item_type q_item,
   output logic                 q_pop,
   output logic                 rsp_valid,
   output logic [2:0]           rsp_kind,
   output logic [63:0]          rsp_out_id,
   output logic [15:0]          rsp_out_size,
   output logic [7:0]           rsp_out_retries,
   output logic                 rsp_table_empty,
   output logic                 rsp_last
);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

   logic [63:0] id_ff [TABLE_DEPTH], id_in [TABLE_DEPTH];
   logic [15:0] size_ff [TABLE_DEPTH], size_in [TABLE_DEPTH];
   logic [31:0] stamp_ff [TABLE_DEPTH], stamp_in [TABLE_DEPTH];
   logic [7:0]  retry_ff [TABLE_DEPTH], retry_in [TABLE_DEPTH];

   rit_pkg::state_type state_ff, state_in;
   rit_pkg::item_type  cur_ff, cur_in;
   logic [CW-1:0] idx_ff, idx_in, wr_ff, wr_in, fcnt_ff, fcnt_in, count_ff, count_in;
   logic          valid_ff, valid_in, last_ff, last_in, empty_ff, empty_in;
   rit_pkg::kind_type kind_ff, kind_in;
   logic [63:0] oid_ff, oid_in;
   logic [15:0] osize_ff, osize_in;
   logic [7:0]  oretry_ff, oretry_in;

   logic [63:0] e_id;
   logic [15:0] e_size;
   logic [31:0] e_stamp, age;
   logic [7:0]  e_retry;
   logic        e_fail, in_range;

   assign e_id = id_ff[idx_ff[IW-1:0]];
   assign e_size = size_ff[idx_ff[IW-1:0]];
   assign e_stamp = stamp_ff[idx_ff[IW-1:0]];
   assign e_retry = retry_ff[idx_ff[IW-1:0]];
   assign e_fail = (e_retry >= cfg.retry_limit);
   assign in_range = (idx_ff < count_ff);
   assign age = cur_ff.now - e_stamp;

   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      idx_in = idx_ff;
      wr_in = wr_ff;
      fcnt_in = fcnt_ff;
      count_in = count_ff;
      q_pop = 1'b0;
      valid_in = 1'b0;
      last_in = 1'b0;
      empty_in = empty_ff;
      kind_in = kind_ff;
      oid_in = oid_ff;
      osize_in = osize_ff;
      oretry_in = oretry_ff;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         id_in[i] = id_ff[i];
         size_in[i] = size_ff[i];
         stamp_in[i] = stamp_ff[i];
         retry_in[i] = retry_ff[i];
      end
      unique case (state_ff)
         rit_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               cur_in = q_item;
               idx_in = '0;
               wr_in = '0;
               fcnt_in = '0;
               unique case (q_item.op)
                  rit_pkg::OP_ADD:    state_in = rit_pkg::ST_ADD;
                  rit_pkg::OP_REMOVE: state_in = rit_pkg::ST_RM_SCAN;
                  rit_pkg::OP_CHECK:  state_in = rit_pkg::ST_CHK_COUNT;
                  default:            state_in = rit_pkg::ST_FORCE;
               endcase
            end
         end
         rit_pkg::ST_ADD: begin
            valid_in = 1'b1;
            empty_in = 1'b0;
            oid_in = cur_ff.id;
            osize_in = cur_ff.size;
            oretry_in = '0;
            if (count_ff == FULL_CNT) begin
               kind_in = rit_pkg::K_FULL;
            end else begin
               kind_in = rit_pkg::K_ADDED;
               id_in[count_ff[IW-1:0]] = cur_ff.id;
               size_in[count_ff[IW-1:0]] = cur_ff.size;
               stamp_in[count_ff[IW-1:0]] = cur_ff.now;
               retry_in[count_ff[IW-1:0]] = '0;
               count_in = count_ff + 1'b1;
            end
            state_in = rit_pkg::ST_DONE;
         end
         rit_pkg::ST_RM_SCAN: begin
            if (in_range) begin
               if (e_id == cur_ff.id) begin
                  valid_in = 1'b1;
                  kind_in = rit_pkg::K_REMOVED;
                  oid_in = cur_ff.id;
                  osize_in = e_size;
                  oretry_in = e_retry;
                  empty_in = (count_ff == CW'(1));
                  state_in = rit_pkg::ST_RM_SHIFT;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else begin
               valid_in = 1'b1;
               kind_in = rit_pkg::K_NOTFOUND;
               oid_in = cur_ff.id;
               osize_in = '0;
               oretry_in = '0;
               empty_in = (count_ff == '0);
               state_in = rit_pkg::ST_DONE;
            end
         end
         rit_pkg::ST_RM_SHIFT: begin
            // close the gap left by the removed entry
            for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
               if (i >= int'(idx_ff)) begin
                  id_in[i] = id_ff[i+1];
                  size_in[i] = size_ff[i+1];
                  stamp_in[i] = stamp_ff[i+1];
                  retry_in[i] = retry_ff[i+1];
               end
            end
            count_in = count_ff - 1'b1;
            state_in = rit_pkg::ST_DONE;
         end
         rit_pkg::ST_CHK_COUNT: begin
            // first pass counts failures so every result knows the final fill
            if (in_range) begin
               if (e_fail) begin
                  fcnt_in = fcnt_ff + 1'b1;
               end
               idx_in = idx_ff + 1'b1;
            end else begin
               idx_in = '0;
               state_in = rit_pkg::ST_CHK_SCAN;
            end
         end
         rit_pkg::ST_CHK_SCAN: begin
            if (in_range) begin
               empty_in = (count_ff == fcnt_ff);
               oid_in = e_id;
               osize_in = e_size;
               idx_in = idx_ff + 1'b1;
               if (e_fail) begin
                  valid_in = 1'b1;
                  kind_in = rit_pkg::K_FAILED;
                  oretry_in = e_retry;
               end else begin
                  // survivors compact toward the front as the walk goes
                  id_in[wr_ff[IW-1:0]] = e_id;
                  size_in[wr_ff[IW-1:0]] = e_size;
                  stamp_in[wr_ff[IW-1:0]] = e_stamp;
                  retry_in[wr_ff[IW-1:0]] = e_retry;
                  wr_in = wr_ff + 1'b1;
                  if (!cur_ff.offline && (age > {16'd0, cfg.resend_interval})) begin
                     valid_in = 1'b1;
                     kind_in = rit_pkg::K_RESEND;
                     oretry_in = e_retry + 8'd1;
                     stamp_in[wr_ff[IW-1:0]] = cur_ff.now;
                     retry_in[wr_ff[IW-1:0]] = e_retry + 8'd1;
                  end
               end
            end else begin
               count_in = wr_ff;
               state_in = rit_pkg::ST_DONE;
            end
         end
         rit_pkg::ST_FORCE: begin
            if (in_range) begin
               valid_in = 1'b1;
               kind_in = rit_pkg::K_FORCE;
               oid_in = e_id;
               osize_in = e_size;
               oretry_in = e_retry;
               empty_in = 1'b0;
               idx_in = idx_ff + 1'b1;
            end else begin
               state_in = rit_pkg::ST_DONE;
            end
         end
         rit_pkg::ST_DONE: begin
            valid_in = 1'b1;
            last_in = 1'b1;
            kind_in = rit_pkg::K_DONE;
            oid_in = '0;
            osize_in = '0;
            oretry_in = '0;
            empty_in = (count_ff == '0);
            state_in = rit_pkg::ST_IDLE;
         end
         default: state_in = rit_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rit_pkg::ST_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
         last_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
         last_ff <= last_in;
      end
      cur_ff <= cur_in;
      idx_ff <= idx_in;
      wr_ff <= wr_in;
      fcnt_ff <= fcnt_in;
      empty_ff <= empty_in;
      kind_ff <= kind_in;
      oid_ff <= oid_in;
      osize_ff <= osize_in;
      oretry_ff <= oretry_in;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         id_ff[i] <= id_in[i];
         size_ff[i] <= size_in[i];
         stamp_ff[i] <= stamp_in[i];
         retry_ff[i] <= retry_in[i];
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_kind = kind_ff;
   assign rsp_out_id = oid_ff;
   assign rsp_out_size = osize_ff;
   assign rsp_out_retries = oretry_ff;
   assign rsp_table_empty = empty_ff;
   assign rsp_last = last_ff;
endmodule
`default_nettype wire

>>> design/retransmit_inflight_table_chk.sv
// port-level checker for the retransmit inflight table, bound to the top
// depends on rit_pkg and the macro header
`default_nettype none
`include "retransmit_inflight_table_top_macros.svh"
module retransmit_inflight_table_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic [2:0]  rsp_kind,
   input wire logic [63:0] rsp_out_id,
   input wire logic        rsp_table_empty,
   input wire logic        rsp_last
);
   `RIT_ASSERT_NEXT(a_reset_quiet, reset, !rsp_valid)
   `RIT_ASSERT_IMPL(a_last_is_done, rsp_valid && rsp_last, rsp_kind == rit_pkg::K_DONE)
   `RIT_ASSERT_IMPL(a_done_is_last, rsp_valid && rsp_kind == rit_pkg::K_DONE, rsp_last)
   `RIT_ASSERT_IMPL(a_done_zero_id, rsp_valid && rsp_last, rsp_out_id == 64'd0)
   `RIT_ASSERT_IMPL(a_added_not_empty, rsp_valid && rsp_kind == rit_pkg::K_ADDED,
                    !rsp_table_empty)
endmodule

bind retransmit_inflight_table_top retransmit_inflight_table_chk u_chk (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_kind(rsp_kind),
   .rsp_out_id(rsp_out_id), .rsp_table_empty(rsp_table_empty), .rsp_last(rsp_last)
);
`default_nettype wire
